>>> design/assert_macros.svh
// Assertion macros shared by the anti-replay window design.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked assertion, disabled while reset is asserted.
`define ARW_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition in one cycle implies an expression in the next cycle.
`define ARW_ASSERT_NEXT(name, clk, rst_n, cond, expr, msg) \
  `ARW_ASSERT(name, clk, rst_n, (cond) |=> (expr), msg)

`endif

>>> design/arw_pkg.sv
// Package for the anti-replay window: widths, register indexes, codes and
// the configuration and status structs used by the bitmap core.
package arw_pkg;

  localparam int WINDOW_WORDS_DEF = 16;
  localparam int WORD_BITS        = 64;
  localparam int ID_W             = 32;
  localparam int CFG_W            = 5;
  localparam int WORDS_CNT_W      = 7;
  localparam int PADDR_W          = 3;
  localparam int PDATA_W          = 32;

  localparam logic [CFG_W-1:0] WINDOW_WORDS_RST = 5'd1;

  // Register index, taken from paddr bit 2.
  localparam logic REG_WINDOW_WORDS = 1'b0;

  typedef enum logic {
    OP_CHECK  = 1'b0,
    OP_UPDATE = 1'b1
  } op_e;

  typedef struct packed {
    logic                   clr;
    logic [WORDS_CNT_W-1:0] words;
  } cfg_t;

  typedef struct packed {
    logic [ID_W-1:0] floor;
  } stat_t;

endpackage

>>> design/arw_in_if.sv
// Input channel of the anti-replay window: one packet id word per handshake.
// Depends on arw_pkg.
interface arw_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [arw_pkg::ID_W-1:0]  pkt_num;

  modport source (output valid, output op, output pkt_num, input ready);
  modport sink (input valid, input op, input pkt_num, output ready);
endinterface

>>> design/arw_out_if.sv
// Result channel of the anti-replay window: one accept flag per word.
// Depends on nothing.
interface arw_out_if;
  logic valid;
  logic ready;
  logic accept;

  modport source (output valid, output accept, input ready);
  modport sink (input valid, input accept, output ready);
endinterface

>>> design/arw_cfg_regs.sv
// APB register block holding window_words and its clamped form.
// Depends on arw_pkg.
module arw_cfg_regs #(
  parameter int WindowWords = arw_pkg::WINDOW_WORDS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [arw_pkg::PADDR_W-1:0]   paddr,
  input  logic [arw_pkg::PDATA_W-1:0]   pwdata,
  output logic [arw_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output arw_pkg::cfg_t                 cfg_o
);

  logic [arw_pkg::CFG_W-1:0]       window_words_q;
  logic [arw_pkg::WORDS_CNT_W-1:0] words_ext;
  logic                            sel_ww;
  logic                            wr_ww;

  assign sel_ww = (paddr[2] == arw_pkg::REG_WINDOW_WORDS);
  assign wr_ww  = psel && penable && pwrite && sel_ww;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_words_q <= arw_pkg::WINDOW_WORDS_RST;
    end else if (wr_ww) begin
      window_words_q <= pwdata[arw_pkg::CFG_W-1:0];
    end
  end

  assign prdata = sel_ww ? arw_pkg::PDATA_W'(window_words_q) : '0;

  // Zero counts as one word; anything above the built size is cut to it.
  assign words_ext = arw_pkg::WORDS_CNT_W'(window_words_q);

  always_comb begin
    cfg_o.clr = wr_ww;
    if (words_ext == '0) begin
      cfg_o.words = arw_pkg::WORDS_CNT_W'(1);
    end else if (words_ext > arw_pkg::WORDS_CNT_W'(WindowWords)) begin
      cfg_o.words = arw_pkg::WORDS_CNT_W'(WindowWords);
    end else begin
      cfg_o.words = words_ext;
    end
  end

endmodule

>>> design/arw_bitmap.sv
// Window floor and seen-bit ring with the per-item check and update logic.
// Depends on arw_pkg.
module arw_bitmap #(
  parameter int WindowWords = arw_pkg::WINDOW_WORDS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  arw_pkg::cfg_t             cfg_i,
  input  logic                      go_i,
  input  logic                      op_i,
  input  logic [arw_pkg::ID_W-1:0]  id_i,
  output logic                      accept_o,
  output arw_pkg::stat_t            stat_o
);

  // Bits are kept in a ring indexed by id modulo a power-of-two size, so a
  // window advance only clears the positions that leave the window.
  localparam int RingBits = 1 << $clog2(WindowWords * arw_pkg::WORD_BITS);
  localparam int RingW    = $clog2(RingBits);
  localparam int IdW      = arw_pkg::ID_W;

  logic [RingBits-1:0] ring_q, ring_d;
  logic [IdW-1:0]      floor_q, floor_d;
  logic [IdW-1:0]      wbits, diff, amount;
  logic                below, ahead, hit, clr_all, do_upd;
  logic [RingW-1:0]    pos;

  assign wbits   = IdW'({cfg_i.words, 6'b0});
  assign below   = id_i < floor_q;
  assign diff    = id_i - floor_q;
  assign ahead   = diff >= wbits;
  assign amount  = diff - wbits + IdW'(1);
  assign clr_all = amount >= wbits;
  assign pos     = id_i[RingW-1:0];
  assign hit     = ring_q[pos];
  assign do_upd  = go_i && (op_i == arw_pkg::OP_UPDATE) && !below;

  always_comb begin
    if (op_i == arw_pkg::OP_UPDATE) begin
      accept_o = !below;
    end else begin
      accept_o = (id_i != '0) && !below && (ahead || !hit);
    end
  end

  always_comb begin
    logic [RingW-1:0] off;
    off     = '0;
    ring_d  = ring_q;
    floor_d = floor_q;
    if (cfg_i.clr) begin
      ring_d  = '0;
      floor_d = '0;
    end else if (do_upd) begin
      if (ahead) begin
        floor_d = floor_q + amount;
        // Drop every position whose id falls below the new floor.
        for (int p = 0; p < RingBits; p++) begin
          off = RingW'(p) - floor_q[RingW-1:0];
          if (clr_all || (off < amount[RingW-1:0])) begin
            ring_d[p] = 1'b0;
          end
        end
      end
      ring_d[pos] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q  <= '0;
      floor_q <= '0;
    end else begin
      ring_q  <= ring_d;
      floor_q <= floor_d;
    end
  end

  assign stat_o.floor = floor_q;

endmodule

>>> design/anti_replay_window_unit.sv
// Top level of the anti-replay window filter.
// Depends on arw_pkg, arw_in_if, arw_out_if, arw_cfg_regs, arw_bitmap and
// assert_macros.svh.
//
// Usage:
//   in_i carries one word per packet: op (check or update) and pkt_num.
//   out_o returns one accept flag for every word, in order.
//   An APB write at byte address 0 sets window_words, clears bitmap and floor.
//   The user makes writes only while no word is pending; it is not enforced.
// Path: an accepted word waits in the input register, passes the bitmap logic
//   when the result register is free or drains, and its flag lands there.
// Throughput: one word per cycle while out_o.ready is high. The input register,
//   one pass through the bitmap logic and the result register set this figure;
//   the floor and the bitmap are written at the same edge that registers the
//   result, so the following word sees them.
// Reset: the pipeline empties, the floor and all bitmap bits go to zero and
//   window_words returns to 1.
// Stall: while out_o.ready is low the result holds, one more word may wait in
//   the input register, and in_i.ready then falls until the result is taken.
`include "assert_macros.svh"

module anti_replay_window_unit #(
  parameter int WindowWords = arw_pkg::WINDOW_WORDS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  arw_in_if.sink                        in_i,
  arw_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [arw_pkg::PADDR_W-1:0]   paddr,
  input  logic [arw_pkg::PDATA_W-1:0]   pwdata,
  output logic [arw_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  arw_pkg::cfg_t                cfg_s;
  arw_pkg::stat_t               stat_s;
  logic                         stg_vld_q;
  logic                         stg_op_q;
  logic [arw_pkg::ID_W-1:0]     stg_id_q;
  logic                         out_vld_q;
  logic                         out_acc_q;
  logic                         adv;
  logic                         take;
  logic                         acc;

  arw_cfg_regs #(
    .WindowWords(WindowWords)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg_s)
  );

  arw_bitmap #(
    .WindowWords(WindowWords)
  ) u_bitmap (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_s),
    .go_i     (adv),
    .op_i     (stg_op_q),
    .id_i     (stg_id_q),
    .accept_o (acc),
    .stat_o   (stat_s)
  );

  // The staged word moves on whenever the result register is free or drains.
  assign adv        = stg_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !stg_vld_q || adv;
  assign take       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (take) begin
        stg_vld_q <= 1'b1;
      end else if (adv) begin
        stg_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      stg_op_q <= in_i.op;
      stg_id_q <= in_i.pkt_num;
    end
    if (adv) begin
      out_acc_q <= acc;
    end
  end

  assign out_o.valid  = out_vld_q;
  assign out_o.accept = out_acc_q;

  `ARW_ASSERT_NEXT(a_stage_kept, clk_i, rst_ni, stg_vld_q && !adv, stg_vld_q,
                   "staged word lost while blocked")
  `ARW_ASSERT_NEXT(a_result_loaded, clk_i, rst_ni, adv, out_vld_q,
                   "advanced word did not reach the result register")
  `ARW_ASSERT_NEXT(a_result_drained, clk_i, rst_ni, out_vld_q && out_o.ready && !adv,
                   !out_vld_q, "taken result was repeated")
  `ARW_ASSERT_NEXT(a_cfg_clears_floor, clk_i, rst_ni, cfg_s.clr, stat_s.floor == '0,
                   "window write did not clear the floor")

endmodule
